// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk in scope; NPM_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define NPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define NPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/npm_pkg.sv =====
package npm_pkg;

    localparam int MEM_WORDS   = 256;
    localparam int STACK_WORDS = 16;
    localparam int NIBBLES     = 32;

    localparam int WORD_W      = 32;
    localparam int PC_W        = 16;
    localparam int PROG_W      = NIBBLES * 4;
    localparam int MEM_AW      = $clog2(MEM_WORDS);
    localparam int STACK_IW    = $clog2(STACK_WORDS);
    localparam int SP_W        = $clog2(STACK_WORDS + 1);
    localparam int NIB_CNT_W   = $clog2(NIBBLES + 1);

    typedef enum logic [3:0] {
        OP_NOP   = 4'h0,
        OP_SHIFT = 4'h1,
        OP_CAR   = 4'h2,
        OP_CDR   = 4'h3,
        OP_XOR   = 4'h4,
        OP_OR    = 4'h5,
        OP_AND   = 4'h6,
        OP_ROL   = 4'h7,
        OP_LOAD  = 4'h8,
        OP_STORE = 4'h9,
        OP_JUMP  = 4'hA,
        OP_CALL  = 4'hB,
        OP_PUSH  = 4'hC,
        OP_POP   = 4'hD,
        OP_CMP   = 4'hE,
        OP_HALT  = 4'hF
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LOAD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [PROG_W-1:0] prog;
        logic [WORD_W-1:0] payload;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] car;
        logic [WORD_W-1:0] cdr;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] step_count;
        logic [4:0]        stack_depth;
        logic              halted_out;
        logic              equal_flag;
        logic [PC_W-1:0]   program_counter;
        logic [WORD_W-1:0] final_cdr;
        logic [WORD_W-1:0] final_car;
        logic [WORD_W-1:0] final_payload;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic load_fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  opcode;
        logic halted;
        logic mem_in_range;
    } status_t;

endpackage

// ===== rtl/npm_ctrl.sv =====
module npm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  npm_pkg::status_t status,
    output npm_pkg::cmd_t    cmd
);
    import npm_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    logic [NIB_CNT_W-1:0]   nib_cnt_reg;
    logic [NIB_CNT_W-1:0]   nib_cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nib_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nib_cnt_reg   <= nib_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        nib_cnt_next = nib_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    nib_cnt_next = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // stop at halt or after the last nibble
                if (status.halted || nib_cnt_reg == NIB_CNT_W'(NIBBLES))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.exec     = 1'b1;
                    nib_cnt_next = nib_cnt_reg + 1'b1;
                    if (status.opcode == OP_LOAD && status.mem_in_range)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_fin = 1'b1;
                state_next   = ST_RUN;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/npm_dp.sv =====
module npm_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  npm_pkg::cmd_t     cmd,
    input  npm_pkg::item_t    item,
    output npm_pkg::status_t  status,
    output npm_pkg::result_t  result
);
    import npm_pkg::*;

    logic [PROG_W-1:0]    prog_reg;
    logic [PROG_W-1:0]    prog_next;
    logic [WORD_W-1:0]    payload_reg;
    logic [WORD_W-1:0]    payload_next;
    logic [WORD_W-1:0]    mask_reg;
    logic [WORD_W-1:0]    mask_next;
    logic [WORD_W-1:0]    car_reg;
    logic [WORD_W-1:0]    car_next;
    logic [WORD_W-1:0]    cdr_reg;
    logic [WORD_W-1:0]    cdr_next;
    logic [PC_W-1:0]      pc_reg;
    logic [PC_W-1:0]      pc_next;
    logic                 flag_reg;
    logic                 flag_next;
    logic                 halt_reg;
    logic                 halt_next;
    logic [WORD_W-1:0]    step_reg;
    logic [WORD_W-1:0]    step_next;
    logic [SP_W-1:0]      sp_reg;
    logic [SP_W-1:0]      sp_next;
    logic [MEM_WORDS-1:0] mem_valid_reg;
    logic [MEM_WORDS-1:0] mem_valid_next;
    result_t              result_reg;

    logic [WORD_W-1:0]    data_mem [MEM_WORDS];
    logic [WORD_W-1:0]    stack_mem [STACK_WORDS];
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    op_t                  opcode;
    logic                 in_range;
    logic [MEM_AW-1:0]    mem_addr;
    logic                 mem_we;
    logic                 mem_re;
    logic                 push_we;
    logic [SP_W-1:0]      sp_dec;

    assign opcode   = op_t'(prog_reg[PROG_W-1 -: 4]);
    assign in_range = (mask_reg < WORD_W'(MEM_WORDS));
    assign mem_addr = mask_reg[MEM_AW-1:0];
    assign sp_dec   = sp_reg - 1'b1;
    assign mem_we   = cmd.exec && opcode == OP_STORE && in_range;
    assign mem_re   = cmd.exec && opcode == OP_LOAD && in_range;
    assign push_we  = cmd.exec && opcode == OP_PUSH && sp_reg < SP_W'(STACK_WORDS);

    always_comb
    begin
        prog_next      = prog_reg;
        payload_next   = payload_reg;
        mask_next      = mask_reg;
        car_next       = car_reg;
        cdr_next       = cdr_reg;
        pc_next        = pc_reg;
        flag_next      = flag_reg;
        halt_next      = halt_reg;
        step_next      = step_reg;
        sp_next        = sp_reg;
        mem_valid_next = mem_valid_reg;
        priority if (cmd.load)
        begin
            prog_next    = item.prog;
            payload_next = item.payload;
            mask_next    = item.mask;
            car_next     = item.car;
            cdr_next     = item.cdr;
        end
        else if (cmd.exec)
        begin
            prog_next = {prog_reg[PROG_W-5:0], 4'h0};
            step_next = step_reg + 1'b1;
            unique case (opcode)
                OP_NOP:   ;
                OP_SHIFT:
                begin
                    car_next = cdr_reg;
                    cdr_next = payload_reg;
                end
                OP_CAR:   payload_next = car_reg;
                OP_CDR:   payload_next = cdr_reg;
                OP_XOR:   payload_next = payload_reg ^ mask_reg;
                OP_OR:    payload_next = payload_reg | mask_reg;
                OP_AND:   payload_next = payload_reg & mask_reg;
                OP_ROL:   payload_next = {payload_reg[WORD_W-2:0], payload_reg[WORD_W-1]};
                OP_LOAD:  ; // payload written in the following cycle if in range
                OP_STORE:
                begin
                    if (in_range)
                    begin
                        mem_valid_next[mem_addr] = 1'b1;
                    end
                end
                OP_JUMP:  pc_next = mask_reg[PC_W-1:0];
                OP_CALL:
                begin
                    cdr_next = WORD_W'(pc_reg);
                    pc_next  = mask_reg[PC_W-1:0];
                end
                OP_PUSH:
                begin
                    if (push_we)
                    begin
                        sp_next = sp_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (sp_reg != '0)
                    begin
                        sp_next      = sp_dec;
                        payload_next = stack_mem[sp_dec[STACK_IW-1:0]];
                    end
                end
                OP_CMP:   flag_next = (payload_reg == mask_reg);
                OP_HALT:  halt_next = 1'b1;
                default:  ;
            endcase
        end
        else if (cmd.load_fin)
        begin
            // never-written words read as zero
            payload_next = rd_valid_reg ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg      <= '0;
            payload_reg   <= '0;
            mask_reg      <= '0;
            car_reg       <= '0;
            cdr_reg       <= '0;
            pc_reg        <= '0;
            flag_reg      <= 1'b0;
            halt_reg      <= 1'b0;
            step_reg      <= '0;
            sp_reg        <= '0;
            mem_valid_reg <= '0;
        end
        else
        begin
            prog_reg      <= prog_next;
            payload_reg   <= payload_next;
            mask_reg      <= mask_next;
            car_reg       <= car_next;
            cdr_reg       <= cdr_next;
            pc_reg        <= pc_next;
            flag_reg      <= flag_next;
            halt_reg      <= halt_next;
            step_reg      <= step_next;
            sp_reg        <= sp_next;
            mem_valid_reg <= mem_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            data_mem[mem_addr] <= payload_reg;
        end
        if (mem_re)
        begin
            rd_data_reg  <= data_mem[mem_addr];
            rd_valid_reg <= mem_valid_reg[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            stack_mem[sp_reg[STACK_IW-1:0]] <= payload_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.final_payload   <= payload_reg;
            result_reg.final_car       <= car_reg;
            result_reg.final_cdr       <= cdr_reg;
            result_reg.program_counter <= pc_reg;
            result_reg.equal_flag      <= flag_reg;
            result_reg.halted_out      <= halt_reg;
            result_reg.stack_depth     <= 5'(sp_reg);
            result_reg.step_count      <= step_reg;
        end
    end

    assign status.opcode       = opcode;
    assign status.halted       = halt_reg;
    assign status.mem_in_range = in_range;
    assign result              = result_reg;

endmodule

// ===== rtl/nibble_program_machine_top.sv =====
// Nibble program machine: each input transaction carries a 32-nibble program
// plus start values for the payload, mask, car and cdr registers. The program
// runs one opcode per clock until the last nibble or a halt, except that a
// memory load in range stalls the program for the registered read. An item
// passes through an accept step, the execute steps with a load step for each
// in-range load, a step that notices the end of the program, and a finish
// step that moves the outcome into the output register. A result still
// waiting in the output register holds the finish step until it is taken.
// Data memory, stack, pc, flag, halt and step count carry over between items;
// halt stays set until reset, and while it is set an item only reloads the
// program and the four registers and reports them. Memory words read as zero
// until written. One result transaction follows each input.
module nibble_program_machine_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // segment0..segment7 (16 each), initial_payload, initial_mask,
    // initial_car, initial_cdr (32 each), lowest bit first
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // final_payload, final_car, final_cdr (32 each), program_counter (16),
    // equal_flag (1), halted_out (1), stack_depth (5), step_count (32),
    // one zero pad bit at the top
    output logic [151:0] m_tdata
);
    import npm_pkg::*;

    `include "assert_macros.svh"

    cmd_t    cmd;
    status_t status;
    item_t   item;
    result_t result;

    // Program order: segment0 high nibble runs first, so it sits at the top.
    assign item.prog    = {s_tdata[15:0],    s_tdata[31:16],
                           s_tdata[47:32],   s_tdata[63:48],
                           s_tdata[79:64],   s_tdata[95:80],
                           s_tdata[111:96],  s_tdata[127:112]};
    assign item.payload = s_tdata[159:128];
    assign item.mask    = s_tdata[191:160];
    assign item.car     = s_tdata[223:192];
    assign item.cdr     = s_tdata[255:224];

    npm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    npm_dp u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .status (status),
        .result (result)
    );

    // Pack the result, lowest field in the lowest bits; pad the top bit.
    assign m_tdata = {1'b0, result};

    // After an accepted item, hold off new input while the program runs.
    `NPM_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "input taken during run")
    // A fresh result appears only out of the finishing step, never from idle.
    `NPM_ASSERT(a_result_from_run, $rose(m_tvalid) |-> $past(!s_tready), "result without a run")
    // The reported stack never holds more words than the stack has.
    `NPM_ASSERT(a_stack_bound, m_tvalid |-> (m_tdata[118:114] <= 5'd16), "stack depth overflow")

endmodule
